// ===== src/bmt_pkg.sv =====
// Shared types and constants of the breakpoint match table.
package bmt_pkg;

    localparam int MAX_ENTRIES_DEF  = 16;
    localparam int MEMORY_WORDS_DEF = 4096;

    // Slot fields are six bits wide, enough to index up to 64 entries.
    localparam int SLOT_W = 6;
    localparam int ADDR_W = 16;
    localparam int HITS_W = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    // Command token that walks down the cell chain, collecting match and free-slot results.
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [HITS_W-1:0] hits;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } t_token;

    // Allocation write broadcast to all cells when an add completes.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
    } t_wr;

endpackage

// ===== src/breakpoint_match_table.sv =====
// Top level of the breakpoint match table: control unit and the chain of entry cells.
//
// The block keeps a table of MAX_ENTRIES breakpoints and takes one command word at a
// time: add, remove or check a 16-bit instruction address. Each entry lives in its own
// cell of a chain, and a command travels down the chain one cell per clock, so the
// lowest enabled match and the lowest reusable slot fall out of the walk in entry order.
// An accepted item passes the register of every cell in the chain, then the result
// stage and then the output register; a new word is taken only once the last result
// has left the result stage, so commands are handled one at a time. A finished
// result may wait in the output register while the next command walks the chain.
// Adds take the lowest freed slot first and otherwise append; the allocation is
// broadcast to all cells when the command leaves the chain. Hit counters saturate at
// 65535. Command code 3 changes nothing and returns an all-zero result.
// Entries need no clearing pass after reset: only enable and allocation bits are reset.
module breakpoint_match_table #(
    parameter int MAX_ENTRIES  = bmt_pkg::MAX_ENTRIES_DEF,
    parameter int MEMORY_WORDS = bmt_pkg::MEMORY_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // [1:0] cmd, [17:2] addr, [23:18] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // [2:0] status, [3] hit, [7:4] slot, [23:8] hit_total
);

    // Token positions along the chain; entry zero is fed by the control unit and
    // the last position returns to it.
    bmt_pkg::t_token tok [0:MAX_ENTRIES];
    bmt_pkg::t_wr    wr;

    bmt_ctrl #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_tok      (tok[0]),
        .i_tok      (tok[MAX_ENTRIES]),
        .o_wr       (wr)
    );

    // Each cell holds one entry and hands the token to the next cell every cycle.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        bmt_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_wr    (wr)
        );
    end

endmodule

// ===== src/bmt_cell.sv =====
// One breakpoint entry of the chain: holds its entry and passes the command token on.
module bmt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmt_pkg::t_token i_tok,
    output bmt_pkg::t_token o_tok,
    input  bmt_pkg::t_wr    i_wr
);

    localparam logic [bmt_pkg::SLOT_W-1:0] MY_SLOT = bmt_pkg::SLOT_W'(CELL_IDX);

    logic [bmt_pkg::ADDR_W-1:0] r_addr;
    logic [bmt_pkg::HITS_W-1:0] r_hits;
    logic                       r_en;
    logic                       r_alloc;
    bmt_pkg::t_token            r_tok;
    bmt_pkg::t_token            n_tok;

    logic                       match;
    logic                       wr_me;
    logic [bmt_pkg::HITS_W-1:0] hits_inc;

    // Only the first enabled match along the chain claims the token.
    assign match    = i_tok.valid && !i_tok.found && r_en && (r_addr == i_tok.addr);
    assign wr_me    = i_wr.en && (i_wr.slot == MY_SLOT);
    assign hits_inc = (r_hits == {bmt_pkg::HITS_W{1'b1}}) ? r_hits : r_hits + 1'b1;

    always_comb begin
        n_tok = i_tok;
        if (match) begin
            n_tok.found = 1'b1;
            n_tok.slot  = MY_SLOT;
            n_tok.hits  = (i_tok.cmd == bmt_pkg::CMD_CHECK) ? hits_inc : r_hits;
        end
        // An allocated but disabled entry can be reused by an add.
        if (i_tok.valid && !i_tok.free_found && r_alloc && !r_en) begin
            n_tok.free_found = 1'b1;
            n_tok.free_slot  = MY_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_alloc   <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (wr_me) begin
                r_en    <= 1'b1;
                r_alloc <= 1'b1;
            end else if (match && (i_tok.cmd == bmt_pkg::CMD_REMOVE)) begin
                r_en <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_me) begin
            r_addr <= i_wr.addr;
            r_hits <= '0;
        end else if (match && (i_tok.cmd == bmt_pkg::CMD_CHECK)) begin
            r_hits <= hits_inc;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/bmt_ctrl.sv =====
// Command entry, result decision, used-slot count and output registers.
module bmt_ctrl #(
    parameter int MAX_ENTRIES  = bmt_pkg::MAX_ENTRIES_DEF,
    parameter int MEMORY_WORDS = bmt_pkg::MEMORY_WORDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [23:0]     i_s_tdata,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [23:0]     o_m_tdata,
    output bmt_pkg::t_token o_tok,
    input  bmt_pkg::t_token i_tok,
    output bmt_pkg::t_wr    o_wr
);

    localparam int UW = $clog2(MAX_ENTRIES + 1);

    logic [UW-1:0] r_used;
    logic          r_busy;
    logic          r_pend_v;
    logic [23:0]   r_pend;
    logic          r_out_v;
    logic [23:0]   r_out;

    logic                        accept;
    logic [bmt_pkg::STAT_W-1:0]  res_status;
    logic                        res_hit;
    logic [bmt_pkg::SLOT_W-1:0]  res_slot;
    logic [bmt_pkg::HITS_W-1:0]  res_total;
    logic                        bump_used;
    logic                        out_load;

    assign o_s_tready = !r_busy && !r_pend_v;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_tok       = '0;
        o_tok.valid = accept;
        o_tok.cmd   = i_s_tdata[1:0];
        o_tok.addr  = i_s_tdata[17:2];
    end

    // Decide the result once the token has passed every cell.
    always_comb begin
        res_status = bmt_pkg::ST_OK;
        res_hit    = 1'b0;
        res_slot   = '0;
        res_total  = '0;
        bump_used  = 1'b0;
        o_wr       = '0;
        o_wr.addr  = i_tok.addr;
        case (i_tok.cmd)
            bmt_pkg::CMD_ADD: begin
                if ({1'b0, i_tok.addr} >= 17'(MEMORY_WORDS)) begin
                    res_status = bmt_pkg::ST_INVALID;
                end else if (i_tok.found) begin
                    res_status = bmt_pkg::ST_DUPLICATE;
                end else if (i_tok.free_found) begin
                    o_wr.en   = i_tok.valid;
                    o_wr.slot = i_tok.free_slot;
                    res_slot  = i_tok.free_slot;
                end else if (r_used == UW'(MAX_ENTRIES)) begin
                    res_status = bmt_pkg::ST_FULL;
                end else begin
                    o_wr.en   = i_tok.valid;
                    o_wr.slot = bmt_pkg::SLOT_W'(r_used);
                    res_slot  = bmt_pkg::SLOT_W'(r_used);
                    bump_used = i_tok.valid;
                end
            end
            bmt_pkg::CMD_REMOVE: begin
                if (i_tok.found) begin
                    res_slot = i_tok.slot;
                end else begin
                    res_status = bmt_pkg::ST_NOT_FOUND;
                end
            end
            bmt_pkg::CMD_CHECK: begin
                if (i_tok.found) begin
                    res_hit   = 1'b1;
                    res_slot  = i_tok.slot;
                    res_total = i_tok.hits;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_load = r_pend_v && (!r_out_v || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_busy   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (bump_used) begin
                r_used <= r_used + 1'b1;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (i_tok.valid) begin
                r_busy <= 1'b0;
            end
            if (i_tok.valid) begin
                r_pend_v <= 1'b1;
            end else if (out_load) begin
                r_pend_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_pend <= {res_total, 4'(res_slot), res_hit, res_status};
        end
        if (out_load) begin
            r_out <= r_pend;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

endmodule

// ===== src/bmt_checker.sv =====
// Port-level checks of the breakpoint match table and their binding.
module bmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // Commands are taken one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second command taken while one is in flight");

    // Not found is the highest status code the block reports.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= bmt_pkg::ST_NOT_FOUND))
        else $error("undefined status code");

    // A hit always reports ok and a counter of at least one.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3]
            |-> (o_m_tdata[2:0] == bmt_pkg::ST_OK) && (o_m_tdata[23:8] != 16'd0))
        else $error("hit with bad status or zero count");

    // Failed commands report neither a hit nor a count.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != bmt_pkg::ST_OK)
            |-> !o_m_tdata[3] && (o_m_tdata[23:8] == 16'd0))
        else $error("failed command with hit data");

endmodule

bind breakpoint_match_table bmt_checker u_bmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/breakpoint_match_table_tb.sv =====
// Self-checking testbench for the breakpoint match table, with a behavioral mirror of the table.
`timescale 1ns / 1ps

// Mirror of the breakpoint table: it predicts the reply word for every accepted
// command word and checks the replies from the block in order.
class bp_table_mirror;

    typedef struct packed {
        logic [15:0] hit_total;
        logic [3:0]  slot;
        logic        hit;
        logic [2:0]  status;
    } t_bp_reply;

    logic [bmt_pkg::ADDR_W-1:0] bp_addr [bmt_pkg::MAX_ENTRIES_DEF];
    bit                         bp_on   [bmt_pkg::MAX_ENTRIES_DEF];
    logic [bmt_pkg::HITS_W-1:0] bp_hits [bmt_pkg::MAX_ENTRIES_DEF];
    int                         alloc_count;
    t_bp_reply                  pending_replies [$];
    int                         errors;

    function new();
        foreach (bp_on[i]) begin
            bp_on[i]   = 1'b0;
            bp_addr[i] = '0;
            bp_hits[i] = '0;
        end
        alloc_count = 0;
        errors      = 0;
    endfunction

    // Lowest enabled entry holding the address, or -1.
    function int lowest_match(logic [bmt_pkg::ADDR_W-1:0] addr);
        for (int i = 0; i < alloc_count; i++) begin
            if (bp_on[i] && bp_addr[i] == addr) return i;
        end
        return -1;
    endfunction

    // Returns the address of some enabled entry, if there is one.
    function bit find_enabled(output logic [bmt_pkg::ADDR_W-1:0] addr);
        addr = '0;
        for (int i = 0; i < alloc_count; i++) begin
            if (bp_on[i]) begin
                addr = bp_addr[i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function int outstanding();
        return pending_replies.size();
    endfunction

    function void log_command(logic [bmt_pkg::CMD_W-1:0] cmd, logic [bmt_pkg::ADDR_W-1:0] addr);
        t_bp_reply reply;
        int        m;
        int        s;
        reply = '0;
        m     = lowest_match(addr);
        case (cmd)
            bmt_pkg::CMD_ADD: begin
                if (addr >= bmt_pkg::MEMORY_WORDS_DEF) begin
                    reply.status = bmt_pkg::ST_INVALID;
                end else if (m >= 0) begin
                    reply.status = bmt_pkg::ST_DUPLICATE;
                end else begin
                    s = -1;
                    for (int i = 0; i < alloc_count; i++) begin
                        if (!bp_on[i]) begin
                            s = i;
                            break;
                        end
                    end
                    if (s < 0) begin
                        if (alloc_count >= bmt_pkg::MAX_ENTRIES_DEF) begin
                            reply.status = bmt_pkg::ST_FULL;
                        end else begin
                            s = alloc_count;
                            alloc_count++;
                        end
                    end
                    if (s >= 0) begin
                        bp_addr[s] = addr;
                        bp_on[s]   = 1'b1;
                        bp_hits[s] = '0;
                        reply.slot = 4'(s);
                    end
                end
            end
            bmt_pkg::CMD_REMOVE: begin
                if (m >= 0) begin
                    bp_on[m]   = 1'b0;
                    reply.slot = 4'(m);
                end else begin
                    reply.status = bmt_pkg::ST_NOT_FOUND;
                end
            end
            bmt_pkg::CMD_CHECK: begin
                if (m >= 0) begin
                    if (bp_hits[m] != 16'hFFFF) bp_hits[m] = bp_hits[m] + 16'd1;
                    reply.hit       = 1'b1;
                    reply.slot      = 4'(m);
                    reply.hit_total = bp_hits[m];
                end
            end
            default: begin
            end
        endcase
        pending_replies.push_back(reply);
    endfunction

    function void check_reply(logic [23:0] word);
        t_bp_reply got;
        t_bp_reply want;
        got = word;
        if (pending_replies.size() == 0) begin
            $error("reply word %h arrived with no command pending", word);
            errors++;
            return;
        end
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errors++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            errors++;
        end
        if (got.hit_total !== want.hit_total) begin
            $error("hit_total: expected %0d, actual %0d", want.hit_total, got.hit_total);
            errors++;
        end
    endfunction

endclass

module breakpoint_match_table_tb;

    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = bmt_pkg::MAX_ENTRIES_DEF + 8;
    localparam int RANDOM_WORDS = 1000;
    localparam int POOL_SIZE    = 20;
    // Length of the closing run of checks on a single entry.
    localparam int HAMMER_RUNS  = 24;

    localparam logic [bmt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;    // [1:0] cmd, [17:2] addr, [23:18] zero
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;        // [2:0] status, [3] hit, [7:4] slot, [23:8] hit_total

    bit             idling_on  = 1'b0;
    int             stall_left = 0;
    int             quiet_cycles = 0;
    bp_table_mirror mirror;
    logic [bmt_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

    breakpoint_match_table #(
        .MAX_ENTRIES  (bmt_pkg::MAX_ENTRIES_DEF),
        .MEMORY_WORDS (bmt_pkg::MEMORY_WORDS_DEF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reply side: take words and check them, with random stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) mirror.check_reply(o_m_tdata);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_tready <= 1'b1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $error("no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one command word, after an optional gap, and returns once it is taken.
    task automatic send_command(input logic [bmt_pkg::CMD_W-1:0] cmd,
                                input logic [bmt_pkg::ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, addr, cmd};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        mirror.log_command(cmd, addr);
    endtask

    initial begin
        int                         pick;
        logic [bmt_pkg::CMD_W-1:0]  op;
        logic [bmt_pkg::ADDR_W-1:0] where;
        logic [bmt_pkg::ADDR_W-1:0] target;

        mirror = new();
        foreach (addr_pool[i]) begin
            addr_pool[i] = 16'($urandom_range(0, bmt_pkg::MEMORY_WORDS_DEF - 1));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The lowest and highest legal addresses go in first, then the
        // out-of-range adds and an enabled duplicate.
        idling_on <= 1'b1;
        send_command(bmt_pkg::CMD_ADD, 16'h0000);
        send_command(bmt_pkg::CMD_ADD, 16'(bmt_pkg::MEMORY_WORDS_DEF - 1));
        send_command(bmt_pkg::CMD_ADD, 16'(bmt_pkg::MEMORY_WORDS_DEF));
        send_command(bmt_pkg::CMD_ADD, 16'hFFFF);
        send_command(bmt_pkg::CMD_ADD, 16'h0000);
        // Repeated checks on one entry count up; a check on an absent address misses.
        send_command(bmt_pkg::CMD_CHECK, 16'h0000);
        send_command(bmt_pkg::CMD_CHECK, 16'h0000);
        send_command(bmt_pkg::CMD_CHECK, 16'(bmt_pkg::MEMORY_WORDS_DEF - 1));
        send_command(bmt_pkg::CMD_CHECK, 16'hFFFF);
        // Remove does no range check, so an out-of-range address simply is not found.
        send_command(bmt_pkg::CMD_REMOVE, 16'hFFFF);
        send_command(bmt_pkg::CMD_REMOVE, 16'h0000);
        // The freed slot zero is reused ahead of appending a new one.
        send_command(bmt_pkg::CMD_ADD, 16'h0AAA);
        // The unused command code must leave the table alone and reply with zeros.
        send_command(CMD_UNUSED, 16'hFFFF);
        // Fill every remaining slot, overflow once, then free a middle slot and reuse it.
        for (int i = 0; i < bmt_pkg::MAX_ENTRIES_DEF - 2; i++) begin
            send_command(bmt_pkg::CMD_ADD, 16'h0100 + 16'(i));
        end
        send_command(bmt_pkg::CMD_ADD, 16'h0200);
        send_command(bmt_pkg::CMD_REMOVE, 16'h0105);
        send_command(bmt_pkg::CMD_ADD, 16'h0200);
        send_command(bmt_pkg::CMD_CHECK, 16'h0200);

        // Random part. Most addresses come from a small pool so that adds, removes and
        // checks keep running into each other; the rest cover the whole 16-bit range.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            idling_on <= ((n / 100) % 3 != 2);
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = bmt_pkg::CMD_ADD;
            else if (pick < 60) op = bmt_pkg::CMD_REMOVE;
            else if (pick < 95) op = bmt_pkg::CMD_CHECK;
            else                op = CMD_UNUSED;
            if ($urandom_range(0, 99) < 85) where = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            else                            where = 16'($urandom);
            send_command(op, where);
        end

        // Last part, without idling: a run of checks on one enabled entry.
        idling_on <= 1'b0;
        if (!mirror.find_enabled(target)) begin
            target = 16'h0123;
            send_command(bmt_pkg::CMD_ADD, target);
        end
        repeat (HAMMER_RUNS) send_command(bmt_pkg::CMD_CHECK, target);
        s_tvalid <= 1'b0;

        while (mirror.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bmt_pkg.sv
src/bmt_cell.sv
src/bmt_ctrl.sv
src/breakpoint_match_table.sv
src/bmt_checker.sv
tb/breakpoint_match_table_tb.sv
